### hdl/i4dp_pkg.sv
package i4dp_pkg;

    // Operand packing
    localparam int LANES       = 8;
    localparam int WORD_W      = 32;
    localparam int NIB_W       = 4;
    localparam int WORD_LANES  = WORD_W / NIB_W;
    // lanes beyond the packed word read as zero, so they are simply not built
    localparam int USED_LANES  = (LANES < WORD_LANES) ? LANES : WORD_LANES;
    localparam int PROD_W      = 2 * NIB_W;
    localparam int ITEM_W      = 11;

    // Accumulator
    localparam int MAX_DEPTH   = 65536;
    localparam int ACC_W       = 24;
    localparam int SUM_EXT_W   = ACC_W + 1;
    localparam int ACC_LIMIT   = 64 * MAX_DEPTH;
    localparam int MAG_W       = ACC_W - 1;

    // Scaling
    localparam int SCALE_W     = 32;
    localparam int VAL_W       = 64;
    localparam int FRAC_SHIFT  = 16;
    localparam int OVF_BIT     = VAL_W - FRAC_SHIFT - 1;
    localparam logic [VAL_W-1:0] ROUND_BIAS = VAL_W'(1) << (FRAC_SHIFT - 1);
    localparam logic [VAL_W-1:0] VAL_MAX    = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN    = {1'b1, {(VAL_W-1){1'b0}}};

    // Job queue
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic signed [ACC_W-1:0] raw_sum;
        logic                    sum_clipped;
        logic [SCALE_W-1:0]      tok_scale;
        logic [SCALE_W-1:0]      chan_scale;
    } t_job;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_MUL_P,
        BS_MUL_H,
        BS_MUL_L,
        BS_ROUND,
        BS_SUM,
        BS_DONE
    } t_bstate;

endpackage

### hdl/i4dp_front.sv
module i4dp_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [31:0]             i_act_word,
    input  logic [31:0]             i_wt_word,
    input  logic [31:0]             i_tok_scale,
    input  logic [31:0]             i_chan_scale,
    input  logic                    i_last,
    output logic                    o_job_push,
    output i4dp_pkg::t_job          o_job
);

    localparam logic signed [i4dp_pkg::SUM_EXT_W-1:0] LIMIT_POS =
        i4dp_pkg::SUM_EXT_W'(i4dp_pkg::ACC_LIMIT);
    localparam logic signed [i4dp_pkg::SUM_EXT_W-1:0] LIMIT_NEG =
        -LIMIT_POS;

    logic signed [i4dp_pkg::ACC_W-1:0]     r_sum;
    logic                                  r_sclip;
    logic signed [i4dp_pkg::ACC_W-1:0]     n_sum;
    logic                                  n_sclip;
    logic signed [i4dp_pkg::ITEM_W-1:0]    item;
    logic signed [i4dp_pkg::SUM_EXT_W-1:0] sum_ext;
    logic signed [i4dp_pkg::NIB_W-1:0]     a_nib;
    logic signed [i4dp_pkg::NIB_W-1:0]     w_nib;
    logic signed [i4dp_pkg::PROD_W-1:0]    lane_prod;
    logic                                  clamp;

    // dot product of one word pair
    always_comb begin
        item      = '0;
        a_nib     = '0;
        w_nib     = '0;
        lane_prod = '0;
        for (int i = 0; i < i4dp_pkg::USED_LANES; i++) begin
            a_nib     = i_act_word[i*i4dp_pkg::NIB_W +: i4dp_pkg::NIB_W];
            w_nib     = i_wt_word[i*i4dp_pkg::NIB_W +: i4dp_pkg::NIB_W];
            lane_prod = a_nib * w_nib;
            item      = item + i4dp_pkg::ITEM_W'(lane_prod);
        end
    end

    // saturating accumulate
    always_comb begin
        sum_ext = i4dp_pkg::SUM_EXT_W'(r_sum) + i4dp_pkg::SUM_EXT_W'(item);
        clamp   = 1'b0;
        if (sum_ext > LIMIT_POS) begin
            sum_ext = LIMIT_POS;
            clamp   = 1'b1;
        end else if (sum_ext < LIMIT_NEG) begin
            sum_ext = LIMIT_NEG;
            clamp   = 1'b1;
        end
        n_sum   = sum_ext[i4dp_pkg::ACC_W-1:0];
        n_sclip = r_sclip | clamp;
    end

    assign o_job_push        = i_accept & i_last;
    assign o_job.raw_sum     = n_sum;
    assign o_job.sum_clipped = n_sclip;
    assign o_job.tok_scale   = i_tok_scale;
    assign o_job.chan_scale  = i_chan_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_sclip <= 1'b0;
        end else if (i_accept) begin
            if (i_last) begin
                r_sum   <= '0;
                r_sclip <= 1'b0;
            end else begin
                r_sum   <= n_sum;
                r_sclip <= n_sclip;
            end
        end
    end

endmodule

### hdl/i4dp_queue.sv
module i4dp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  i4dp_pkg::t_job i_job,
    input  logic           i_pop,
    output i4dp_pkg::t_job o_job,
    output logic           o_full,
    output logic           o_empty
);

    i4dp_pkg::t_job                r_mem [i4dp_pkg::QDEPTH];
    logic [i4dp_pkg::QPTR_W-1:0]   r_wptr;
    logic [i4dp_pkg::QPTR_W-1:0]   r_rptr;
    logic [i4dp_pkg::QCNT_W-1:0]   r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_count == i4dp_pkg::QCNT_W'(i4dp_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hdl/i4dp_back.sv
module i4dp_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  i4dp_pkg::t_job         i_job,
    input  logic                   i_q_empty,
    output logic                   o_q_pop,
    input  logic                   i_pop,
    output logic                   o_empty,
    output logic signed [63:0]     o_scaled_value,
    output logic signed [23:0]     o_raw_sum,
    output logic                   o_clipped
);

    i4dp_pkg::t_bstate                  r_state;
    i4dp_pkg::t_bstate                  n_state;

    logic                               r_neg;
    logic [i4dp_pkg::MAG_W-1:0]         r_mag;
    logic signed [i4dp_pkg::ACC_W-1:0]  r_raw;
    logic                               r_sclip;
    logic [i4dp_pkg::SCALE_W-1:0]       r_as;
    logic [i4dp_pkg::SCALE_W-1:0]       r_ws;
    logic [i4dp_pkg::VAL_W-1:0]         r_p;
    logic [i4dp_pkg::VAL_W-1:0]         r_mh;
    logic [i4dp_pkg::VAL_W-1:0]         r_ml;
    logic [i4dp_pkg::VAL_W-1:0]         r_t;
    logic                               r_ovf;
    logic [i4dp_pkg::VAL_W-1:0]         r_q;

    logic                               r_out_valid;
    logic [i4dp_pkg::VAL_W-1:0]         r_out_value;
    logic signed [i4dp_pkg::ACC_W-1:0]  r_out_raw;
    logic                               r_out_clip;

    logic [i4dp_pkg::SCALE_W-1:0]       mul_a;
    logic [i4dp_pkg::SCALE_W-1:0]       mul_b;
    logic [i4dp_pkg::VAL_W-1:0]         prod;
    logic signed [i4dp_pkg::ACC_W-1:0]  job_abs;
    logic                               out_pop;
    logic                               done_write;
    logic                               clip;
    logic [i4dp_pkg::VAL_W-1:0]         res_value;

    assign out_pop    = i_pop & r_out_valid;
    assign done_write = (r_state == i4dp_pkg::BS_DONE) & (~r_out_valid | out_pop);

    // one shared 32x32 multiplier
    assign prod = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i4dp_pkg::BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            i4dp_pkg::BS_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = i4dp_pkg::BS_MUL_P;
                end
            end
            i4dp_pkg::BS_MUL_P: begin
                mul_a   = r_as;
                mul_b   = r_ws;
                n_state = i4dp_pkg::BS_MUL_H;
            end
            i4dp_pkg::BS_MUL_H: begin
                mul_a   = i4dp_pkg::SCALE_W'(r_mag);
                mul_b   = r_p[i4dp_pkg::SCALE_W +: i4dp_pkg::SCALE_W];
                n_state = i4dp_pkg::BS_MUL_L;
            end
            i4dp_pkg::BS_MUL_L: begin
                mul_a   = i4dp_pkg::SCALE_W'(r_mag);
                mul_b   = r_p[i4dp_pkg::SCALE_W-1:0];
                n_state = i4dp_pkg::BS_ROUND;
            end
            i4dp_pkg::BS_ROUND: begin
                n_state = i4dp_pkg::BS_SUM;
            end
            i4dp_pkg::BS_SUM: begin
                n_state = i4dp_pkg::BS_DONE;
            end
            i4dp_pkg::BS_DONE: begin
                if (!r_out_valid || out_pop) begin
                    n_state = i4dp_pkg::BS_IDLE;
                end
            end
            default: begin
                n_state = i4dp_pkg::BS_IDLE;
            end
        endcase
    end

    assign job_abs = i_job.raw_sum[i4dp_pkg::ACC_W-1] ? -i_job.raw_sum : i_job.raw_sum;

    always_ff @(posedge i_clk) begin
        case (r_state)
            i4dp_pkg::BS_IDLE: begin
                if (!i_q_empty) begin
                    r_neg   <= i_job.raw_sum[i4dp_pkg::ACC_W-1];
                    r_mag   <= job_abs[i4dp_pkg::MAG_W-1:0];
                    r_raw   <= i_job.raw_sum;
                    r_sclip <= i_job.sum_clipped;
                    r_as    <= i_job.tok_scale;
                    r_ws    <= i_job.chan_scale;
                end
            end
            i4dp_pkg::BS_MUL_P: r_p  <= prod;
            i4dp_pkg::BS_MUL_H: r_mh <= prod;
            i4dp_pkg::BS_MUL_L: r_ml <= prod;
            i4dp_pkg::BS_ROUND: begin
                r_t   <= (r_ml + i4dp_pkg::ROUND_BIAS) >> i4dp_pkg::FRAC_SHIFT;
                r_ovf <= |r_mh[i4dp_pkg::VAL_W-1:i4dp_pkg::OVF_BIT];
            end
            i4dp_pkg::BS_SUM: begin
                r_q <= (r_mh << i4dp_pkg::FRAC_SHIFT) + r_t;
            end
            default: ;
        endcase
    end

    // saturate the magnitude, then restore the sign
    always_comb begin
        clip = r_ovf
             | (~r_neg & r_q[i4dp_pkg::VAL_W-1])
             | (r_neg & r_q[i4dp_pkg::VAL_W-1] & (|r_q[i4dp_pkg::VAL_W-2:0]));
        if (clip) begin
            res_value = r_neg ? i4dp_pkg::VAL_MIN : i4dp_pkg::VAL_MAX;
        end else begin
            res_value = r_neg ? (~r_q + 1'b1) : r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_write) begin
            r_out_valid <= 1'b1;
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_write) begin
            r_out_value <= res_value;
            r_out_raw   <= r_raw;
            r_out_clip  <= clip | r_sclip;
        end
    end

    assign o_empty        = ~r_out_valid;
    assign o_scaled_value = r_out_value;
    assign o_raw_sum      = r_out_raw;
    assign o_clipped      = r_out_clip;

endmodule

### hdl/int4_dot_product_dequant.sv
// int4 x int4 dot product with Q16.16 dequantisation.
// Input request: i_push with the packed activation and weight words, both
// scales and i_last; taken at a rising edge with i_push high and o_full low.
// Requests without i_last only accumulate; a request with i_last closes the
// dot product and yields one result request (scaled value, raw sum, clipped).
// Results: o_empty low means a result is on the output ports; i_pop takes it.
// Throughput: one input request per cycle while o_full is low. Each result
// occupies the scaling unit for a fetch from the queue, one shared 32x32
// multiplier used three times, then rounding, summing and saturation; the
// unit fetches a new closing sum only after the last one has been written
// to the result register.
// A two-entry queue sits between accumulator and scaling unit; o_full rises
// when both entries hold finished sums, i.e. when the scaling unit is behind.
// A stalled receiver holds the result register, then the scaling unit, then
// fills the queue; accumulation carries on until the queue is full.
// Reset (synchronous, i_rst_n low) clears the accumulator, the queue and the
// result valid flag; no result is pending afterwards.
module int4_dot_product_dequant (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [31:0]        i_act_word,
    input  logic [31:0]        i_wt_word,
    input  logic [31:0]        i_tok_scale,
    input  logic [31:0]        i_chan_scale,
    input  logic               i_last,
    output logic               o_empty,
    input  logic               i_pop,
    output logic signed [63:0] o_scaled_value,
    output logic signed [23:0] o_raw_sum,
    output logic               o_clipped
);

    logic            in_accept;
    logic            job_push;
    i4dp_pkg::t_job  job_in;
    i4dp_pkg::t_job  job_out;
    logic            q_empty;
    logic            q_pop;

    // take the request only while the queue can hold a closing sum
    assign in_accept = i_push & ~o_full;

    // front: unpack, multiply lanes, accumulate with clamping
    i4dp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_act_word   (i_act_word),
        .i_wt_word    (i_wt_word),
        .i_tok_scale  (i_tok_scale),
        .i_chan_scale (i_chan_scale),
        .i_last       (i_last),
        .o_job_push   (job_push),
        .o_job        (job_in)
    );

    // hold closed sums until the scaling unit is free
    i4dp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (q_pop),
        .o_job   (job_out),
        .o_full  (o_full),
        .o_empty (q_empty)
    );

    // back: scale, round, saturate and present the result
    i4dp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (job_out),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_scaled_value (o_scaled_value),
        .o_raw_sum      (o_raw_sum),
        .o_clipped      (o_clipped)
    );

endmodule
